// File: src/egf_pkg.sv
// shared types and constants for the gray emboss filter
package egf_pkg;

    localparam int unsigned MAX_WIDTH_DEF = 4096;

    localparam int unsigned CH_W      = 16;
    localparam int unsigned DEPTH_W   = 9;
    localparam int unsigned WIDTH_W   = 13;
    localparam int unsigned HEIGHT_W  = 16;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 16;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 3'd3;

    localparam logic [DEPTH_W-1:0]  DEPTH_RST  = 9'd30;
    localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 13'd640;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 16'd480;

    // arithmetic widths and reciprocal constants
    localparam int unsigned Q_W   = 27;
    localparam int unsigned MAG_W = 26;
    localparam int unsigned V_W   = 22;
    localparam int unsigned SUM_W = 24;

    localparam int unsigned DIV10_MUL_W = 27;
    localparam int unsigned DIV10_SHIFT = 30;
    localparam logic [DIV10_MUL_W-1:0] DIV10_MUL = 27'd107374183;

    localparam int unsigned DIV3_MUL_W = 25;
    localparam int unsigned DIV3_SHIFT = 26;
    localparam logic [DIV3_MUL_W-1:0] DIV3_MUL = 25'd22369622;

    localparam logic signed [Q_W-1:0] MID10_WIDE   = 27'sd327680;
    localparam logic signed [Q_W-1:0] MID10_NARROW = 27'sd1280;

    typedef struct packed {
        logic [CH_W-1:0] alpha_in;
        logic [CH_W-1:0] blue_in;
        logic [CH_W-1:0] green_in;
        logic [CH_W-1:0] red_in;
    } t_pix_in;

    typedef struct packed {
        logic [CH_W-1:0] gray_out;
        logic [CH_W-1:0] alpha_out;
        logic            run_last;
        logic            image_done;
    } t_pix_out;

    typedef struct packed {
        logic    valid;
        t_pix_in self;
        t_pix_in nb;
        logic    run_last;
        logic    image_done;
    } t_issue;

endpackage

// File: src/egf_gray_pipe.sv
// three-stage gray emboss datapath: channel gain, divide by ten, sum and divide by three
module egf_gray_pipe (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  egf_pkg::t_issue               i_issue,
    input  logic [egf_pkg::DEPTH_W-1:0]   i_depth,
    input  logic                          i_wide,
    output logic                          o_valid,
    output egf_pkg::t_pix_out             o_res
);

    localparam int unsigned P10_W = egf_pkg::MAG_W + egf_pkg::DIV10_MUL_W;
    localparam int unsigned P3_W  = egf_pkg::SUM_W + egf_pkg::DIV3_MUL_W;

    function automatic logic [egf_pkg::CH_W-1:0] chan_val(
        input logic [egf_pkg::CH_W-1:0] v,
        input logic                     wide
    );
        return wide ? v : {8'd0, v[7:0]};
    endfunction

    function automatic logic [egf_pkg::MAG_W-1:0] chan_mag(
        input logic [egf_pkg::CH_W-1:0]    a,
        input logic [egf_pkg::CH_W-1:0]    b,
        input logic [egf_pkg::DEPTH_W-1:0] depth,
        input logic                        wide
    );
        logic signed [egf_pkg::Q_W-1:0] d;
        logic signed [egf_pkg::Q_W-1:0] g;
        logic signed [egf_pkg::Q_W-1:0] q;
        d = $signed(egf_pkg::Q_W'(a)) - $signed(egf_pkg::Q_W'(b));
        g = $signed(egf_pkg::Q_W'(depth));
        q = d * g + (wide ? egf_pkg::MID10_WIDE : egf_pkg::MID10_NARROW);
        return q[egf_pkg::Q_W-1] ? egf_pkg::MAG_W'(-q) : egf_pkg::MAG_W'(q);
    endfunction

    logic [egf_pkg::CH_W-1:0]  self_ch [3];
    logic [egf_pkg::CH_W-1:0]  nb_ch   [3];
    logic [egf_pkg::MAG_W-1:0] n_p1_mag [3];
    logic [egf_pkg::MAG_W-1:0] r_p1_mag [3];
    logic [egf_pkg::CH_W-1:0]  r_p1_alpha;
    logic                      r_p1_valid;
    logic                      r_p1_last;
    logic                      r_p1_done;

    logic [P10_W-1:0]          p10 [3];
    logic [egf_pkg::V_W-1:0]   n_p2_v [3];
    logic [egf_pkg::V_W-1:0]   r_p2_v [3];
    logic [egf_pkg::CH_W-1:0]  r_p2_alpha;
    logic                      r_p2_valid;
    logic                      r_p2_last;
    logic                      r_p2_done;

    logic [egf_pkg::SUM_W-1:0] sum;
    logic [P3_W-1:0]           p3;
    logic [egf_pkg::V_W-1:0]   g;
    logic [egf_pkg::CH_W-1:0]  lim;
    logic [egf_pkg::CH_W-1:0]  n_gray;
    logic [egf_pkg::CH_W-1:0]  r_gray;
    logic [egf_pkg::CH_W-1:0]  r_alpha;
    logic                      r_last;
    logic                      r_done;
    logic                      r_out_valid;

    assign self_ch[0] = i_issue.self.red_in;
    assign self_ch[1] = i_issue.self.green_in;
    assign self_ch[2] = i_issue.self.blue_in;
    assign nb_ch[0]   = i_issue.nb.red_in;
    assign nb_ch[1]   = i_issue.nb.green_in;
    assign nb_ch[2]   = i_issue.nb.blue_in;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_p1_mag[c] = chan_mag(chan_val(self_ch[c], i_wide), chan_val(nb_ch[c], i_wide),
                                   i_depth, i_wide);
        end
    end

    // divide by ten through a reciprocal multiply
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            p10[c]    = P10_W'(r_p1_mag[c]) * P10_W'(egf_pkg::DIV10_MUL);
            n_p2_v[c] = p10[c][egf_pkg::DIV10_SHIFT +: egf_pkg::V_W];
        end
    end

    always_comb begin
        sum    = egf_pkg::SUM_W'(r_p2_v[0]) + egf_pkg::SUM_W'(r_p2_v[1])
               + egf_pkg::SUM_W'(r_p2_v[2]);
        p3     = P3_W'(sum) * P3_W'(egf_pkg::DIV3_MUL);
        g      = p3[egf_pkg::DIV3_SHIFT +: egf_pkg::V_W];
        lim    = i_wide ? 16'hFFFF : 16'h00FF;
        n_gray = (g > egf_pkg::V_W'(lim)) ? lim : g[egf_pkg::CH_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid  <= 1'b0;
            r_p2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (i_en) begin
            r_p1_valid  <= i_issue.valid;
            r_p2_valid  <= r_p1_valid;
            r_out_valid <= r_p2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p1_mag   <= n_p1_mag;
            r_p1_alpha <= chan_val(i_issue.self.alpha_in, i_wide);
            r_p1_last  <= i_issue.run_last;
            r_p1_done  <= i_issue.image_done;
            r_p2_v     <= n_p2_v;
            r_p2_alpha <= r_p1_alpha;
            r_p2_last  <= r_p1_last;
            r_p2_done  <= r_p1_done;
            r_gray     <= n_gray;
            r_alpha    <= r_p2_alpha;
            r_last     <= r_p2_last;
            r_done     <= r_p2_done;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_res.gray_out   = r_gray;
    assign o_res.alpha_out  = r_alpha;
    assign o_res.run_last   = r_last;
    assign o_res.image_done = r_done;

endmodule

// File: src/emboss_gray_filter.sv
// top level of the gray emboss filter: position tracking, line store, result sequencing
//
// pixels arrive in raster order on the input channel (i_valid / o_ready, one pixel a beat);
// gray emboss results leave on the output channel (o_valid / i_ready) in raster order, but
// the last two rows interleave. each pixel is compared with its down-right neighbor, so a
// result leaves once that neighbor has arrived: a pixel gives no result in the first row, one
// result inside the image, two at a row end, and up to four in the last row (run_last marks
// the last one, image_done the final pixel of the image).
// registers are written on the cfg channel (i_cfg_valid / o_cfg_ready, always ready);
// writing the width or height restarts at the first pixel of a new image.
// the first result of a pixel passes the registered stages of egf_gray_pipe before o_valid.
// throughput: one pixel a cycle while each gives at most one result and the receiver does not stall;
// further results hold o_ready low, since the pipeline issues one result a cycle when not stalled.
// the line store is one memory of MAX_WIDTH pixels, read and written once per pixel.
// reset restores the register defaults and the position counters; the line store is not
// cleared, as a row is read only after it was written.
// when the receiver stalls, the whole result pipeline holds and o_ready drops once the
// current pixel still has results waiting.
module emboss_gray_filter #(
    parameter int unsigned MAX_WIDTH = egf_pkg::MAX_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  egf_pkg::t_pix_in                i_pix,
    output logic                            o_valid,
    input  logic                            i_ready,
    output egf_pkg::t_pix_out               o_res,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [egf_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [egf_pkg::CFG_DAT_W-1:0]   i_cfg_data
);

    localparam int unsigned CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int unsigned WEW = 18;

    logic [egf_pkg::DEPTH_W-1:0]  r_depth;
    logic                         r_wide;
    logic [egf_pkg::WIDTH_W-1:0]  r_width;
    logic [egf_pkg::HEIGHT_W-1:0] r_height;
    logic [CW-1:0]                r_col;
    logic [egf_pkg::HEIGHT_W-1:0] r_row;

    logic [WEW-1:0]               w_nz;
    logic [WEW-1:0]               w_eff;
    logic [CW-1:0]                last_col;
    logic [egf_pkg::HEIGHT_W-1:0] last_y;
    logic [CW-1:0]                x;
    logic [egf_pkg::HEIGHT_W-1:0] y;
    logic                         row_end;
    logic                         last_row;

    egf_pkg::t_pix_in             r_row_mem [MAX_WIDTH];
    egf_pkg::t_pix_in             r_rd;
    egf_pkg::t_pix_in             r_a_cur;
    egf_pkg::t_pix_in             r_a_left;
    egf_pkg::t_pix_in             r_a_prior;
    logic [3:0]                   r_a_pend;
    logic [3:0]                   n_a_pend;
    logic [3:0]                   lowest;
    logic [3:0]                   rest;
    logic [3:0]                   new_pend;

    egf_pkg::t_issue              issue;
    logic                         pipe_valid;
    logic                         en;
    logic                         in_acc;
    logic                         cfg_acc;
    logic                         geo_wr;

    // geometry with zero and oversize values folded in
    always_comb begin
        w_nz     = (r_width == '0) ? WEW'(1) : WEW'(r_width);
        w_eff    = (w_nz > WEW'(MAX_WIDTH)) ? WEW'(MAX_WIDTH) : w_nz;
        last_col = CW'(w_eff - WEW'(1));
        last_y   = (r_height == '0) ? '0 : r_height - 16'd1;
        x        = (r_col > last_col) ? '0 : r_col;
        y        = (r_row > last_y) ? '0 : r_row;
        row_end  = (x == last_col);
        last_row = (y == last_y);
        new_pend = {last_row && row_end, last_row && (x != '0), row_end && (y != '0),
                    (x != '0) && (y != '0)};
    end

    // issue the lowest pending result of the held pixel
    always_comb begin
        lowest           = r_a_pend & (~r_a_pend + 4'd1);
        rest             = r_a_pend & ~lowest;
        issue.valid      = (r_a_pend != '0);
        issue.nb         = r_a_cur;
        issue.run_last   = (rest == '0);
        issue.image_done = lowest[3];
        if (lowest[0]) begin
            issue.self = r_a_left;
        end else if (lowest[1]) begin
            issue.self = r_rd;
        end else if (lowest[2]) begin
            issue.self = r_a_prior;
        end else begin
            issue.self = r_a_cur;
        end
    end

    assign en          = !pipe_valid || i_ready;
    assign o_ready     = (r_a_pend == '0) || (en && (rest == '0));
    assign in_acc      = i_valid && o_ready;
    assign o_cfg_ready = 1'b1;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;
    assign geo_wr      = cfg_acc
                         && (i_cfg_index inside {egf_pkg::CFG_WIDTH, egf_pkg::CFG_HEIGHT});
    assign o_valid     = pipe_valid;

    always_comb begin
        if (in_acc) begin
            n_a_pend = new_pend;
        end else if (en) begin
            n_a_pend = rest;
        end else begin
            n_a_pend = r_a_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth  <= egf_pkg::DEPTH_RST;
            r_wide   <= 1'b0;
            r_width  <= egf_pkg::WIDTH_RST;
            r_height <= egf_pkg::HEIGHT_RST;
            r_col    <= '0;
            r_row    <= '0;
            r_a_pend <= '0;
        end else begin
            r_a_pend <= n_a_pend;
            // a geometry write restarts the image
            if (geo_wr) begin
                r_col <= '0;
                r_row <= '0;
            end else if (in_acc) begin
                if (row_end) begin
                    r_col <= '0;
                    r_row <= last_row ? '0 : y + 16'd1;
                end else begin
                    r_col <= x + CW'(1);
                end
            end
            if (cfg_acc) begin
                unique case (i_cfg_index)
                    egf_pkg::CFG_DEPTH:  r_depth  <= i_cfg_data[egf_pkg::DEPTH_W-1:0];
                    egf_pkg::CFG_WIDE:   r_wide   <= i_cfg_data[0];
                    egf_pkg::CFG_WIDTH:  r_width  <= i_cfg_data[egf_pkg::WIDTH_W-1:0];
                    egf_pkg::CFG_HEIGHT: r_height <= i_cfg_data[egf_pkg::HEIGHT_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // line store: read the row above at this column, then overwrite it with this pixel
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_rd         <= r_row_mem[x];
            r_row_mem[x] <= i_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_a_prior <= r_a_cur;
            r_a_cur   <= i_pix;
            r_a_left  <= r_rd;
        end
    end

    egf_gray_pipe u_pipe (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_issue (issue),
        .i_depth (r_depth),
        .i_wide  (r_wide),
        .o_valid (pipe_valid),
        .o_res   (o_res)
    );

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_res.image_done |-> o_res.run_last)
        else $error("image_done without run_last");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col <= last_col)
        else $error("column counter past row end");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row <= last_y)
        else $error("row counter past image end");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(r_a_pend) || $past(in_acc))
        else $error("pending results lost during output stall");

endmodule

// File: tb/egf_checker.sv
// checker for the gray emboss filter: mirrors the filter state, predicts results, compares beats
module egf_checker
    import egf_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_pix_valid,
    input  logic                 i_pix_ready,
    input  t_pix_in              i_pix,
    input  logic                 i_res_valid,
    input  logic                 i_res_ready,
    input  t_pix_out             i_res,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned PRINT_CAP = 40;
    localparam int unsigned LW        = $clog2(MAX_WIDTH_DEF);

    logic [DEPTH_W-1:0]  depth_q;
    logic                wide_q;
    logic [WIDTH_W-1:0]  width_q;
    logic [HEIGHT_W-1:0] height_q;
    t_pix_in             line_mem [MAX_WIDTH_DEF];
    t_pix_in             prior_q;
    int unsigned         col_q;
    int unsigned         row_q;
    t_pix_out            gray_due [$];
    int                  fail_cnt = 0;
    int                  pend_cnt = 0;

    assign o_fail_count = fail_cnt;
    assign o_pending    = pend_cnt;

    task automatic report_mismatch(string what);
        fail_cnt++;
        if (fail_cnt <= PRINT_CAP) begin
            $display("[%0t] mismatch: %s", $time, what);
        end
    endtask

    function automatic logic [CH_W-1:0] sample_of(logic [CH_W-1:0] v);
        return wide_q ? v : {8'h00, v[7:0]};
    endfunction

    function automatic longint chan_mag(logic [CH_W-1:0] a, logic [CH_W-1:0] b);
        longint mid;
        longint diff;
        longint t;
        mid  = wide_q ? 32768 : 128;
        diff = longint'(sample_of(a)) - longint'(sample_of(b));
        t    = (diff * longint'(depth_q) + 10 * mid) / 10;
        return (t < 0) ? -t : t;
    endfunction

    function automatic t_pix_out emboss_of(t_pix_in self_px, t_pix_in nb_px, logic done);
        t_pix_out r;
        longint   sum;
        longint   lim;
        sum = chan_mag(self_px.red_in, nb_px.red_in)
            + chan_mag(self_px.green_in, nb_px.green_in)
            + chan_mag(self_px.blue_in, nb_px.blue_in);
        sum = sum / 3;
        lim = wide_q ? 65535 : 255;
        if (sum > lim) begin
            sum = lim;
        end
        r.gray_out   = sum[CH_W-1:0];
        r.alpha_out  = sample_of(self_px.alpha_in);
        r.run_last   = 1'b0;
        r.image_done = done;
        return r;
    endfunction

    task automatic predict_emboss(t_pix_in cur);
        int unsigned w;
        int unsigned h;
        int unsigned x;
        int unsigned y;
        logic        row_end;
        logic        last_row;
        t_pix_out    batch [$];
        t_pix_out    tail;
        w = (width_q == 0) ? 1 : 32'(width_q);
        if (w > MAX_WIDTH_DEF) begin
            w = MAX_WIDTH_DEF;
        end
        h = (height_q == 0) ? 1 : 32'(height_q);
        if (col_q >= w) begin
            col_q = 0;
        end
        if (row_q >= h) begin
            row_q = 0;
        end
        x        = col_q;
        y        = row_q;
        row_end  = (x == w - 1);
        last_row = (y == h - 1);
        if (x >= 1) begin
            if (y >= 1) begin
                batch.push_back(emboss_of(line_mem[LW'(x - 1)], cur, 1'b0));
            end
            line_mem[LW'(x - 1)] = prior_q;
        end
        if (row_end) begin
            if (y >= 1) begin
                batch.push_back(emboss_of(line_mem[LW'(x)], cur, 1'b0));
            end
            line_mem[LW'(x)] = cur;
        end
        if (last_row) begin
            if (x >= 1) begin
                batch.push_back(emboss_of(prior_q, cur, 1'b0));
            end
            if (row_end) begin
                batch.push_back(emboss_of(cur, cur, 1'b1));
            end
        end
        if (batch.size() > 0) begin
            tail          = batch.pop_back();
            tail.run_last = 1'b1;
            batch.push_back(tail);
        end
        foreach (batch[i]) begin
            gray_due.push_back(batch[i]);
        end
        prior_q = cur;
        if (row_end) begin
            col_q = 0;
            row_q = last_row ? 0 : y + 1;
        end else begin
            col_q = x + 1;
        end
    endtask

    task automatic check_result(t_pix_out got);
        t_pix_out want;
        if (gray_due.size() == 0) begin
            report_mismatch($sformatf("unexpected beat gray %0d alpha %0d",
                                      got.gray_out, got.alpha_out));
        end else begin
            want = gray_due.pop_front();
            if (got.gray_out !== want.gray_out) begin
                report_mismatch($sformatf("gray_out got %0d exp %0d",
                                          got.gray_out, want.gray_out));
            end
            if (got.alpha_out !== want.alpha_out) begin
                report_mismatch($sformatf("alpha_out got %0d exp %0d",
                                          got.alpha_out, want.alpha_out));
            end
            if (got.run_last !== want.run_last) begin
                report_mismatch($sformatf("run_last got %b exp %b",
                                          got.run_last, want.run_last));
            end
            if (got.image_done !== want.image_done) begin
                report_mismatch($sformatf("image_done got %b exp %b",
                                          got.image_done, want.image_done));
            end
        end
    endtask

    task automatic apply_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
        case (idx)
            CFG_DEPTH: begin
                depth_q = data[DEPTH_W-1:0];
            end
            CFG_WIDE: begin
                wide_q = data[0];
            end
            CFG_WIDTH: begin
                width_q = data[WIDTH_W-1:0];
                col_q   = 0;
                row_q   = 0;
            end
            CFG_HEIGHT: begin
                height_q = data[HEIGHT_W-1:0];
                col_q    = 0;
                row_q    = 0;
            end
            default: begin
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            depth_q  = DEPTH_RST;
            wide_q   = 1'b0;
            width_q  = WIDTH_RST;
            height_q = HEIGHT_RST;
            prior_q  = '0;
            col_q    = 0;
            row_q    = 0;
            gray_due.delete();
        end else begin
            if (i_res_valid && i_res_ready) begin
                check_result(i_res);
            end
            if (i_cfg_valid && i_cfg_ready) begin
                apply_cfg(i_cfg_index, i_cfg_data);
            end
            if (i_pix_valid && i_pix_ready) begin
                predict_emboss(i_pix);
            end
        end
        pend_cnt = gray_due.size();
    end

endmodule

// File: tb/tb.sv
// testbench top for the gray emboss filter: clock, reset, stimulus and verdict
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import egf_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_HEIGHT + 1'b1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = '1;
    localparam int unsigned RANDOM_ITEMS  = 260;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned DRAIN_LIMIT   = 20000;
    localparam int unsigned TAIL_CYCLES   = 20;
    localparam int unsigned WIDE_ROW_PX   = 16;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_ready;
    t_pix_in              i_pix;
    logic                 o_valid;
    logic                 i_ready;
    t_pix_out             o_res;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_DAT_W-1:0] i_cfg_data;
    int                   fails;
    int                   pending;
    bit                   tx_idle_en = 1'b1;
    bit                   rx_idle_en = 1'b1;

    emboss_gray_filter i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_pix       (i_pix),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_res       (o_res),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    egf_checker u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pix_valid  (i_valid),
        .i_pix_ready  (o_ready),
        .i_pix        (i_pix),
        .i_res_valid  (o_valid),
        .i_res_ready  (i_ready),
        .i_res        (o_res),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fails),
        .o_pending    (pending)
    );

    always #5ns i_clk = ~i_clk;

    function automatic t_pix_in mk_pix(logic [CH_W-1:0] r, logic [CH_W-1:0] g,
                                       logic [CH_W-1:0] b, logic [CH_W-1:0] a);
        t_pix_in p;
        p.red_in   = r;
        p.green_in = g;
        p.blue_in  = b;
        p.alpha_in = a;
        return p;
    endfunction

    function automatic logic [CH_W-1:0] rand_chan();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return 16'h00FF;
            3:       return 16'hFF00;
            default: return CH_W'($urandom);
        endcase
    endfunction

    function automatic t_pix_in rand_pixel();
        return mk_pix(rand_chan(), rand_chan(), rand_chan(), rand_chan());
    endfunction

    function automatic int unsigned pick_depth();
        case ($urandom_range(0, 5))
            0:       return 0;
            1:       return 300;
            2:       return $urandom_range(301, 511);
            default: return $urandom_range(1, 299);
        endcase
    endfunction

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, int unsigned val);
        logic [CFG_DAT_W-1:0] word;
        word = CFG_DAT_W'($urandom);
        case (idx)
            CFG_DEPTH:  word[DEPTH_W-1:0] = val[DEPTH_W-1:0];
            CFG_WIDE:   word[0]           = val[0];
            CFG_WIDTH:  word[WIDTH_W-1:0] = val[WIDTH_W-1:0];
            CFG_HEIGHT: word              = val[HEIGHT_W-1:0];
            default:    word              = word;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= word;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_pixel(t_pix_in px);
        int unsigned gap;
        gap = tx_idle_en ? $urandom_range(0, 14) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_pix   <= px;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // hold the sender until every predicted beat has left the block
    task automatic settle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    initial begin
        int unsigned gap;
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            gap = rx_idle_en ? $urandom_range(0, 14) : 0;
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_valid && i_ready));
        end
    end

    initial begin
        int unsigned rand_sent;
        int unsigned wv;
        int unsigned hv;
        int unsigned image_px;
        int unsigned count;
        int unsigned wait_cnt;
        bit          retune;

        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_pix       = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_DEPTH;
        i_cfg_data  = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // register defaults: first row of a large image gives nothing
        send_pixel(mk_pix(16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0));
        send_pixel(mk_pix('1, '1, '1, '1));
        send_pixel(mk_pix('0, '0, '0, '0));
        settle();

        // default depth and narrow samples on a 2x2 image
        cfg_write(CFG_WIDTH, 2);
        cfg_write(CFG_HEIGHT, 2);
        send_pixel(mk_pix('0, '0, '0, '0));
        send_pixel(mk_pix('1, '1, '1, '1));
        send_pixel(mk_pix(16'h12FF, 16'hAB00, 16'h00FF, 16'hFF80));
        send_pixel(mk_pix(16'hFF00, 16'h0001, 16'hFFFF, 16'h007F));
        settle();

        // top depth, wide samples
        cfg_write(CFG_DEPTH, 300);
        cfg_write(CFG_WIDE, 1);
        cfg_write(CFG_WIDTH, 3);
        cfg_write(CFG_HEIGHT, 2);
        send_pixel(mk_pix('1, '1, '1, '1));
        send_pixel(mk_pix('0, '0, '0, '0));
        send_pixel(mk_pix('0, '0, '0, 16'h8001));
        send_pixel(mk_pix('1, '1, '1, '0));
        send_pixel(mk_pix(16'h8000, 16'h7FFF, 16'h0001, 16'hFFFE));
        send_pixel(mk_pix('0, '0, '0, '0));
        settle();

        // depth past its range, zero width, then zero height
        cfg_write(CFG_DEPTH, 511);
        cfg_write(CFG_WIDTH, 0);
        cfg_write(CFG_HEIGHT, 3);
        send_pixel(mk_pix('1, '1, '1, '1));
        send_pixel(mk_pix('0, '0, '0, '0));
        send_pixel(mk_pix('1, '0, '1, 16'h00FF));
        settle();
        cfg_write(CFG_WIDTH, 1);
        cfg_write(CFG_HEIGHT, 0);
        send_pixel(mk_pix('0, '1, '0, 16'hFF00));
        send_pixel(mk_pix('1, '0, '1, '1));
        settle();

        // zero depth, geometry rewritten mid-image, writes past the register list
        cfg_write(CFG_DEPTH, 0);
        cfg_write(CFG_WIDE, 0);
        cfg_write(CFG_WIDTH, 2);
        cfg_write(CFG_HEIGHT, 4);
        send_pixel(mk_pix(16'h0080, 16'h0040, 16'h00C0, 16'h1111));
        send_pixel(mk_pix('1, '0, '1, '0));
        send_pixel(mk_pix(16'h7F7F, 16'h8080, '0, '1));
        settle();
        for (int i = CFG_SPARE_LO; i <= CFG_SPARE_HI; i++) begin
            cfg_write(CFG_IDX_W'(i), $urandom);
        end
        cfg_write(CFG_HEIGHT, 2);
        send_pixel(mk_pix('1, '1, '0, '0));
        send_pixel(mk_pix('0, '1, '1, 16'hABCD));
        send_pixel(mk_pix(16'h00FF, 16'hFF00, 16'h0F0F, 16'hF0F0));
        send_pixel(mk_pix('0, '0, '1, '1));
        settle();

        rand_sent = 0;
        while (rand_sent < RANDOM_ITEMS) begin
            settle();
            tx_idle_en = ($urandom_range(0, 3) != 0);
            rx_idle_en = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 3) == 0) begin
                cfg_write(CFG_IDX_W'($urandom_range(CFG_SPARE_LO, CFG_SPARE_HI)), $urandom);
            end
            cfg_write(CFG_DEPTH, pick_depth());
            cfg_write(CFG_WIDE, $urandom_range(0, 1));
            case ($urandom_range(0, 7))
                0:       wv = 0;
                1:       wv = 1;
                2:       wv = $urandom_range(9, 24);
                default: wv = $urandom_range(2, 8);
            endcase
            case ($urandom_range(0, 7))
                0:       hv = 0;
                1:       hv = 1;
                default: hv = $urandom_range(2, 5);
            endcase
            cfg_write(CFG_WIDTH, wv);
            cfg_write(CFG_HEIGHT, hv);
            image_px = ((wv == 0) ? 1 : wv) * ((hv == 0) ? 1 : hv);
            if ($urandom_range(0, 3) == 0) begin
                count = $urandom_range(1, 2 * image_px);
            end else begin
                count = image_px * $urandom_range(1, 2);
            end
            if (count > RANDOM_ITEMS - rand_sent) begin
                count = RANDOM_ITEMS - rand_sent;
            end
            retune = ($urandom_range(0, 2) == 0);
            for (int unsigned i = 0; i < count; i++) begin
                if (retune && i == count / 2) begin
                    settle();
                    cfg_write(CFG_DEPTH, pick_depth());
                    cfg_write(CFG_WIDE, $urandom_range(0, 1));
                end
                send_pixel(rand_pixel());
            end
            rand_sent += count;
        end

        // width register above the line store depth, single-row image, no idling
        settle();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        cfg_write(CFG_DEPTH, pick_depth());
        cfg_write(CFG_WIDE, $urandom_range(0, 1));
        cfg_write(CFG_WIDTH, 8191);
        cfg_write(CFG_HEIGHT, 1);
        for (int unsigned i = 0; i < WIDE_ROW_PX; i++) begin
            send_pixel(rand_pixel());
        end

        @(negedge i_clk);
        i_valid <= 1'b0;
        wait_cnt = 0;
        while (pending != 0 && wait_cnt < DRAIN_LIMIT) begin
            @(negedge i_clk);
            wait_cnt++;
        end
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (fails == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
